// ----- hw/rtl/ccs_pkg.sv -----
package ccs_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
        logic       text_end;
    } t_ccs_res;

    // results produced by one accepted word
    typedef struct packed {
        logic [1:0] cnt;
        t_ccs_res   res0;
        t_ccs_res   res1;
    } t_ccs_push;

endpackage

// ----- hw/rtl/ccs_if.sv -----
interface ccs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface ccs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_end;
    logic       text_end;

    modport source (output valid, output out_char, output run_end, output text_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_end, input text_end,
                    output ready);
endinterface

// ----- hw/rtl/c_comment_stripper.sv -----
// channel   | dir | payload                       | handshake
// i_in      | in  | in_char[7:0], in_last         | valid/ready
// o_out     | out | out_char[7:0], run_end, text_end | valid/ready
// cfg       | in  | i_cfg_wdata[3:0] newline limit | i_cfg_we, no stall
//
// one word per cycle in while i_in.ready is high; each word yields zero, one or two result words
// a word is lexed in the cycle it is accepted and its results land in a
// four-entry result queue; i_in.ready drops while fewer than two slots are free
// output drains one word per cycle while o_out.ready is high, so two-result words slow intake briefly
// synchronous active-low reset: normal text mode, newline run zero, limit 2,
// queue empty
module c_comment_stripper
    import ccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    ccs_in_if.sink     i_in,
    ccs_out_if.source  o_out
);

    logic [3:0] r_max_run;
    logic       take;
    logic       room;
    t_ccs_push  push;

    // newline limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run <= 4'd2;
        end else if (i_cfg_we) begin
            r_max_run <= i_cfg_wdata;
        end
    end

    // accept only with space for a worst-case pair of results
    assign i_in.ready = room;
    assign take       = i_in.valid & room;

    // lexer state machine and per-word result build
    ccs_lexer u_lexer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_char    (i_in.in_char),
        .i_last    (i_in.in_last),
        .i_max_run (r_max_run),
        .o_push    (push)
    );

    // result queue, parts the output side from the lexer
    ccs_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (take),
        .i_push    (push),
        .o_room    (room),
        .o_out     (o_out)
    );

endmodule

// ----- hw/rtl/ccs_lexer.sv -----
module ccs_lexer
    import ccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char,
    input  logic       i_last,
    input  logic [3:0] i_max_run,
    output t_ccs_push  o_push
);

    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_SLASH      = 3'd1;
    localparam logic [2:0] MODE_STRING     = 3'd2;
    localparam logic [2:0] MODE_LINE       = 3'd3;
    localparam logic [2:0] MODE_BLOCK      = 3'd4;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd5;

    logic [2:0] r_mode, n_mode;
    logic [3:0] r_run, n_run;

    always_comb begin
        logic       e0, e1;
        logic [7:0] c0, c1;
        logic       pass_in;
        logic [7:0] pass_ch;
        logic       norm_in;
        e0      = 1'b0;
        e1      = 1'b0;
        c0      = i_char;
        c1      = i_char;
        pass_in = 1'b0;
        pass_ch = i_char;
        norm_in = 1'b0;
        n_mode  = r_mode;
        n_run   = r_run;

        case (r_mode)
            MODE_SLASH: begin
                if (i_char == CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end else if (i_char == CH_SLASH) begin
                    n_mode = MODE_LINE;
                end else begin
                    // held slash goes out, then the byte as normal text
                    e0      = 1'b1;
                    c0      = CH_SLASH;
                    n_run   = '0;
                    n_mode  = MODE_NORMAL;
                    norm_in = 1'b1;
                end
            end
            MODE_STRING: begin
                e0    = 1'b1;
                n_run = '0;
                if (i_char == CH_QUOTE) begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_LINE: begin
                if (i_char == CH_NEWLINE) begin
                    n_mode  = MODE_NORMAL;
                    pass_in = 1'b1;
                end
            end
            MODE_BLOCK: begin
                if (i_char == CH_STAR) begin
                    n_mode = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                if (i_char == CH_SLASH) begin
                    n_mode = MODE_NORMAL;
                end else if (i_char != CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end
            end
            default: begin
                n_mode  = MODE_NORMAL;
                norm_in = 1'b1;
            end
        endcase

        // normal text handling of the input byte
        if (norm_in) begin
            if (i_char == CH_SLASH) begin
                if (i_last) begin
                    pass_in = 1'b1;
                end else begin
                    n_mode = MODE_SLASH;
                end
            end else if (i_char == CH_QUOTE) begin
                if (e0) begin
                    e1 = 1'b1;
                end else begin
                    e0 = 1'b1;
                end
                n_run  = '0;
                n_mode = MODE_STRING;
            end else begin
                pass_in = 1'b1;
            end
        end

        // plain text with newline limit
        if (pass_in) begin
            if (pass_ch == CH_NEWLINE) begin
                if (n_run < i_max_run) begin
                    if (e0) begin
                        e1 = 1'b1;
                    end else begin
                        e0 = 1'b1;
                    end
                    n_run = n_run + 4'd1;
                end
            end else begin
                if (e0) begin
                    e1 = 1'b1;
                end else begin
                    e0 = 1'b1;
                end
                n_run = '0;
            end
        end

        if (i_last) begin
            n_mode = MODE_NORMAL;
            n_run  = '0;
        end

        o_push.cnt           = {e1, e0 & ~e1};
        o_push.res0.out_char = c0;
        o_push.res0.run_end  = e0 & ~e1;
        o_push.res0.text_end = e0 & ~e1 & i_last;
        o_push.res1.out_char = c1;
        o_push.res1.run_end  = 1'b1;
        o_push.res1.text_end = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_run  <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_run  <= n_run;
        end
    end

endmodule

// ----- hw/rtl/ccs_outq.sv -----
module ccs_outq
    import ccs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_en,
    input  t_ccs_push i_push,
    output logic      o_room,
    ccs_out_if.source o_out
);

    t_ccs_res          r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [1:0]        push_n;
    logic              pop;

    assign push_n = i_push_en ? i_push.cnt : 2'd0;
    assign pop    = o_out.valid & o_out.ready;

    // room for the two results one word can cause
    assign o_room = (r_cnt <= QCNT_W'(QDEPTH - 2));

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_char = r_q[r_rd].out_char;
    assign o_out.run_end  = r_q[r_rd].run_end;
    assign o_out.text_end = r_q[r_rd].text_end;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QDEPTH; k++) begin
            if (push_n != 2'd0 && QPTR_W'(k) == r_wr) begin
                r_q[k] <= i_push.res0;
            end else if (push_n == 2'd2 && QPTR_W'(k) == r_wr + QPTR_W'(1)) begin
                r_q[k] <= i_push.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QPTR_W'(push_n);
            r_rd  <= r_rd + QPTR_W'(pop);
            r_cnt <= r_cnt + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

endmodule
